[src/ialu_pkg.sv]
package ialu_pkg;

  localparam logic [3:0] MODE_ADD  = 4'd0;
  localparam logic [3:0] MODE_SUB  = 4'd1;
  localparam logic [3:0] MODE_DIV  = 4'd2;
  localparam logic [3:0] MODE_MUL  = 4'd3;
  localparam logic [3:0] MODE_MOD  = 4'd4;
  localparam logic [3:0] MODE_AND  = 4'd5;
  localparam logic [3:0] MODE_OR   = 4'd6;
  localparam logic [3:0] MODE_XOR  = 4'd7;
  localparam logic [3:0] MODE_SHR  = 4'd8;
  localparam logic [3:0] MODE_SHL  = 4'd9;
  localparam logic [3:0] MODE_ROTL = 4'd10;
  localparam logic [3:0] MODE_ROTR = 4'd11;

  // What the cell chain does with a word.
  typedef enum logic [2:0] {
    KIND_PASS = 3'd0,
    KIND_MUL  = 3'd1,
    KIND_DIV  = 3'd2,
    KIND_MOD  = 3'd3,
    KIND_ROT  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  neg;   // Negate the result, or rotate right for rotates.
    logic  uns;
    logic  err;
  } ctrl_t;

endpackage

[src/ialu_cell.sv]
module ialu_cell #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  ialu_pkg::ctrl_t      ctrl_i,
  input  logic [WORD_BITS-1:0] rem_i,
  input  logic [WORD_BITS-1:0] q_i,
  input  logic [WORD_BITS-1:0] d_i,
  input  logic [WORD_BITS-1:0] res_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output ialu_pkg::ctrl_t      ctrl_o,
  output logic [WORD_BITS-1:0] rem_o,
  output logic [WORD_BITS-1:0] q_o,
  output logic [WORD_BITS-1:0] d_o,
  output logic [WORD_BITS-1:0] res_o
);

  logic                 valid_r;
  ialu_pkg::ctrl_t      ctrl_r;
  logic [WORD_BITS-1:0] rem_r, q_r, d_r, res_r;
  logic [WORD_BITS-1:0] rem_nxt, q_nxt, d_nxt;
  logic [WORD_BITS-1:0] trial;

  assign ready_o = !valid_r || ready_i;

  // One step: shift-add for MUL, a restoring division step for DIV, MOD and ROT.
  always_comb begin
    trial   = {rem_i[WORD_BITS-2:0], q_i[WORD_BITS-1]};
    rem_nxt = rem_i;
    q_nxt   = q_i;
    d_nxt   = d_i;
    case (ctrl_i.kind) inside
      ialu_pkg::KIND_MUL: begin
        if (d_i[0]) begin
          rem_nxt = rem_i + q_i;
        end
        q_nxt = {q_i[WORD_BITS-2:0], 1'b0};
        d_nxt = {1'b0, d_i[WORD_BITS-1:1]};
      end
      ialu_pkg::KIND_DIV, ialu_pkg::KIND_MOD, ialu_pkg::KIND_ROT: begin
        if (trial >= d_i) begin
          rem_nxt = trial - d_i;
          q_nxt   = {q_i[WORD_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt   = {q_i[WORD_BITS-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      ctrl_r <= ctrl_i;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      d_r    <= d_nxt;
      res_r  <= res_i;
    end
  end

  assign valid_o = valid_r;
  assign ctrl_o  = ctrl_r;
  assign rem_o   = rem_r;
  assign q_o     = q_r;
  assign d_o     = d_r;
  assign res_o   = res_r;

endmodule

[src/integer_alu_32bit.sv]
// Each word passes through a chain of WORD_BITS cell registers and then the output
// register before its result word can be taken.
// Throughput: one word per cycle unless out_ready stalls the output; multiply, divide,
// modulo and the rotate amount reduction each take one step per cell of a chain of
// WORD_BITS cells. Stalls at the output fill empty cells before in_ready drops.
// Reset (synchronous, active low) empties the chain and the output register.
module integer_alu_32bit #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           in_mode,
  input  logic [WORD_BITS-1:0] in_operand_a,
  input  logic [WORD_BITS-1:0] in_operand_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] out_result_bits,
  output logic                 out_is_unsigned,
  output logic                 out_div_zero_error
);

  localparam logic [WORD_BITS-1:0] WBITS = (WORD_BITS)'(WORD_BITS);

  logic                 c_valid [WORD_BITS+1];
  logic                 c_ready [WORD_BITS+1];
  ialu_pkg::ctrl_t      c_ctrl  [WORD_BITS+1];
  logic [WORD_BITS-1:0] c_rem   [WORD_BITS+1];
  logic [WORD_BITS-1:0] c_q     [WORD_BITS+1];
  logic [WORD_BITS-1:0] c_d     [WORD_BITS+1];
  logic [WORD_BITS-1:0] c_res   [WORD_BITS+1];

  logic [WORD_BITS-1:0] mag_a, mag_b;
  logic                 neg_a, neg_b;

  assign neg_a = in_operand_a[WORD_BITS-1];
  assign neg_b = in_operand_b[WORD_BITS-1];
  assign mag_a = neg_a ? -in_operand_a : in_operand_a;
  assign mag_b = neg_b ? -in_operand_b : in_operand_b;

  // Set up each word for the chain; add, subtract, logic and shift results are computed here.
  always_comb begin
    c_valid[0] = in_valid;
    c_ctrl[0]  = '{kind: ialu_pkg::KIND_PASS, neg: 1'b0, uns: 1'b1, err: 1'b0};
    c_rem[0]   = '0;
    c_q[0]     = in_operand_a;
    c_d[0]     = in_operand_b;
    c_res[0]   = '0;
    unique case (in_mode) inside
      ialu_pkg::MODE_ADD: begin
        c_ctrl[0].uns = 1'b0;
        c_res[0]      = in_operand_a + in_operand_b;
      end
      ialu_pkg::MODE_SUB: begin
        c_ctrl[0].uns = 1'b0;
        c_res[0]      = in_operand_a - in_operand_b;
      end
      ialu_pkg::MODE_MUL: begin
        c_ctrl[0].uns  = 1'b0;
        c_ctrl[0].kind = ialu_pkg::KIND_MUL;
      end
      ialu_pkg::MODE_DIV, ialu_pkg::MODE_MOD: begin
        c_ctrl[0].uns = 1'b0;
        if (in_operand_b == '0) begin
          c_ctrl[0].err = 1'b1;
        end else begin
          c_ctrl[0].kind = (in_mode == ialu_pkg::MODE_DIV) ? ialu_pkg::KIND_DIV
                                                           : ialu_pkg::KIND_MOD;
          c_ctrl[0].neg  = (in_mode == ialu_pkg::MODE_DIV) ? (neg_a ^ neg_b) : neg_a;
          c_q[0]         = mag_a;
          c_d[0]         = mag_b;
        end
      end
      ialu_pkg::MODE_AND: c_res[0] = in_operand_a & in_operand_b;
      ialu_pkg::MODE_OR:  c_res[0] = in_operand_a | in_operand_b;
      ialu_pkg::MODE_XOR: c_res[0] = in_operand_a ^ in_operand_b;
      ialu_pkg::MODE_SHR: c_res[0] = (in_operand_b >= WBITS) ? '0 : in_operand_a >> in_operand_b;
      ialu_pkg::MODE_SHL: c_res[0] = (in_operand_b >= WBITS) ? '0 : in_operand_a << in_operand_b;
      ialu_pkg::MODE_ROTL, ialu_pkg::MODE_ROTR: begin
        // The chain divides the amount by the word width; the remainder is the rotation.
        c_ctrl[0].kind = ialu_pkg::KIND_ROT;
        c_ctrl[0].neg  = (in_mode == ialu_pkg::MODE_ROTR);
        c_q[0]         = in_operand_b;
        c_d[0]         = WBITS;
        c_res[0]       = in_operand_a;
      end
      default: begin
      end
    endcase
  end

  assign in_ready = c_ready[0];

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    ialu_cell #(.WORD_BITS(WORD_BITS)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (c_valid[i]),
      .ready_o (c_ready[i]),
      .ctrl_i  (c_ctrl[i]),
      .rem_i   (c_rem[i]),
      .q_i     (c_q[i]),
      .d_i     (c_d[i]),
      .res_i   (c_res[i]),
      .valid_o (c_valid[i+1]),
      .ready_i (c_ready[i+1]),
      .ctrl_o  (c_ctrl[i+1]),
      .rem_o   (c_rem[i+1]),
      .q_o     (c_q[i+1]),
      .d_o     (c_d[i+1]),
      .res_o   (c_res[i+1])
    );
  end

  logic                 out_valid_r;
  logic [WORD_BITS-1:0] result_r, result_nxt;
  logic                 uns_r, err_r;
  logic [WORD_BITS-1:0] rot_amt;
  ialu_pkg::ctrl_t      last;

  assign last                = c_ctrl[WORD_BITS];
  assign rot_amt             = c_rem[WORD_BITS];
  assign c_ready[WORD_BITS]  = !out_valid_r || out_ready;

  always_comb begin
    case (last.kind)
      ialu_pkg::KIND_MUL: result_nxt = c_rem[WORD_BITS];
      ialu_pkg::KIND_DIV: result_nxt = last.neg ? -c_q[WORD_BITS] : c_q[WORD_BITS];
      ialu_pkg::KIND_MOD: result_nxt = last.neg ? -c_rem[WORD_BITS] : c_rem[WORD_BITS];
      ialu_pkg::KIND_ROT: begin
        if (last.neg) begin
          result_nxt = (c_res[WORD_BITS] >> rot_amt) | (c_res[WORD_BITS] << (WBITS - rot_amt));
        end else begin
          result_nxt = (c_res[WORD_BITS] << rot_amt) | (c_res[WORD_BITS] >> (WBITS - rot_amt));
        end
      end
      default: result_nxt = c_res[WORD_BITS];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (c_ready[WORD_BITS]) begin
      out_valid_r <= c_valid[WORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready[WORD_BITS] && c_valid[WORD_BITS]) begin
      result_r <= result_nxt;
      uns_r    <= last.uns;
      err_r    <= last.err;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_bits    = result_r;
  assign out_is_unsigned    = uns_r;
  assign out_div_zero_error = err_r;

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WB = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [3:0]    mode;
    logic [WB-1:0] a;
    logic [WB-1:0] b;
  } op_word_t;

  typedef struct packed {
    logic [WB-1:0] bits;
    logic          uns;
    logic          err;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_mode = '0;
  logic [WB-1:0] in_operand_a = '0;
  logic [WB-1:0] in_operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WB-1:0] out_result_bits;
  logic out_is_unsigned;
  logic out_div_zero_error;

  op_word_t pending_ops[$];
  alu_result_t expected_results[$];
  int errors = 0;
  int accepted_in = 0;
  int accepted_out = 0;
  int idle_cycles = 0;
  bit stimulus_done = 0;
  int in_gap = 0;
  int out_gap = 0;

  integer_alu_32bit #(.WORD_BITS(WB)) u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic alu_result_t alu_predict(op_word_t w);
    alu_result_t r;
    logic [WB-1:0] ma, mb, q;
    logic na, nb;
    int amt;
    r.bits = '0;
    r.uns = 1'b1;
    r.err = 1'b0;
    case (w.mode) inside
      ialu_pkg::MODE_ADD: begin
        r.bits = w.a + w.b;
        r.uns = 1'b0;
      end
      ialu_pkg::MODE_SUB: begin
        r.bits = w.a - w.b;
        r.uns = 1'b0;
      end
      ialu_pkg::MODE_MUL: begin
        r.bits = w.a * w.b;
        r.uns = 1'b0;
      end
      ialu_pkg::MODE_DIV, ialu_pkg::MODE_MOD: begin
        r.uns = 1'b0;
        if (w.b == '0) begin
          r.err = 1'b1;
        end else begin
          na = w.a[WB-1];
          nb = w.b[WB-1];
          ma = na ? -w.a : w.a;
          mb = nb ? -w.b : w.b;
          if (w.mode == ialu_pkg::MODE_DIV) begin
            q = ma / mb;
            r.bits = (na != nb) ? -q : q;
          end else begin
            q = ma % mb;
            r.bits = na ? -q : q;
          end
        end
      end
      ialu_pkg::MODE_AND: r.bits = w.a & w.b;
      ialu_pkg::MODE_OR:  r.bits = w.a | w.b;
      ialu_pkg::MODE_XOR: r.bits = w.a ^ w.b;
      ialu_pkg::MODE_SHR: r.bits = (w.b >= WB) ? '0 : w.a >> w.b;
      ialu_pkg::MODE_SHL: r.bits = (w.b >= WB) ? '0 : w.a << w.b;
      ialu_pkg::MODE_ROTL: begin
        amt = w.b % WB;
        r.bits = (amt == 0) ? w.a : ((w.a << amt) | (w.a >> (WB - amt)));
      end
      ialu_pkg::MODE_ROTR: begin
        amt = w.b % WB;
        r.bits = (amt == 0) ? w.a : ((w.a >> amt) | (w.a << (WB - amt)));
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [WB-1:0] random_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      4: return $urandom_range(0, 70);
      5: return -$urandom_range(1, 70);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(logic [3:0] m, logic [WB-1:0] a, logic [WB-1:0] b);
    op_word_t w;
    w.mode = m;
    w.a = a;
    w.b = b;
    pending_ops.push_back(w);
  endtask

  task automatic w_drive(op_word_t w);
    in_valid <= 1'b1;
    in_mode <= w.mode;
    in_operand_a <= w.a;
    in_operand_b <= w.b;
  endtask

  initial begin
    op_word_t w;
    add_op(ialu_pkg::MODE_ADD, 32'h7fff_ffff, 32'd1);
    add_op(ialu_pkg::MODE_SUB, 32'h8000_0000, 32'd1);
    add_op(ialu_pkg::MODE_MUL, 32'hffff_ffff, 32'h8000_0000);
    add_op(ialu_pkg::MODE_DIV, 32'd100, 32'd0);
    add_op(ialu_pkg::MODE_MOD, 32'h8000_0000, 32'd0);
    add_op(ialu_pkg::MODE_DIV, 32'h8000_0000, 32'hffff_ffff);
    add_op(ialu_pkg::MODE_MOD, 32'h8000_0000, 32'hffff_ffff);
    add_op(ialu_pkg::MODE_DIV, -32'd7, 32'd2);
    add_op(ialu_pkg::MODE_MOD, -32'd7, 32'd2);
    add_op(ialu_pkg::MODE_MOD, 32'd7, -32'd2);
    add_op(ialu_pkg::MODE_AND, 32'hffff_ffff, 32'ha5a5_5a5a);
    add_op(ialu_pkg::MODE_OR, 32'h0000_0000, 32'h5a5a_a5a5);
    add_op(ialu_pkg::MODE_XOR, 32'hffff_ffff, 32'h1234_5678);
    add_op(ialu_pkg::MODE_SHR, 32'h8000_0000, 32'd31);
    add_op(ialu_pkg::MODE_SHR, 32'hffff_ffff, 32'd32);
    add_op(ialu_pkg::MODE_SHL, 32'h0000_0001, 32'd31);
    add_op(ialu_pkg::MODE_SHL, 32'hffff_ffff, 32'hffff_ffff);
    add_op(ialu_pkg::MODE_ROTL, 32'h8000_0001, 32'd0);
    add_op(ialu_pkg::MODE_ROTL, 32'h8000_0001, 32'd33);
    add_op(ialu_pkg::MODE_ROTR, 32'h8000_0001, 32'd32);
    add_op(ialu_pkg::MODE_ROTR, 32'h0000_0003, 32'hffff_ffff);
    for (int m = 12; m < 16; m++) add_op(m[3:0], 32'hdead_beef, 32'h1);
    for (int i = 0; i < 1100; i++) begin
      w.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                            : 4'($urandom_range(0, 11));
      w.a = random_operand();
      w.b = random_operand();
      if (w.mode >= ialu_pkg::MODE_SHR && $urandom_range(0, 1)) w.b = $urandom_range(0, 40);
      pending_ops.push_back(w);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: one word at a time, with a random gap between words.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(alu_predict({in_mode, in_operand_a, in_operand_b}));
        accepted_in++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          w_drive(pending_ops.pop_front());
          in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        end else begin
          in_valid <= 1'b0;
          stimulus_done <= 1'b1;
        end
      end
    end
  end

  // Monitor: compares each result word with the oldest prediction.
  always @(posedge clk) begin
    alu_result_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        accepted_out++;
        if (expected_results.size() == 0) begin
          $error("result word with no expectation: %h", out_result_bits);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_result_bits !== e.bits) begin
            $error("result_bits expected %h actual %h", e.bits, out_result_bits);
            errors++;
          end
          if (out_is_unsigned !== e.uns) begin
            $error("is_unsigned expected %b actual %b", e.uns, out_is_unsigned);
            errors++;
          end
          if (out_div_zero_error !== e.err) begin
            $error("div_zero_error expected %b actual %b", e.err, out_div_zero_error);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid) out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done && expected_results.size() == 0);
    repeat (2 * WB + 10) @(posedge clk);
    if (expected_results.size() != 0) errors++;
    $display("Ran %0d operations through all twelve opcodes and the unused ones,", accepted_in);
    $display("%0d result words checked, %0d errors.", accepted_out, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
